@@ sv/wst_pkg.sv @@
// Shared widths, entry field positions and the chain token type.
`default_nettype none
package wst_pkg;

	localparam int unsigned MAX_ENTRIES = 8;
	localparam int unsigned ENTRY_W     = 30;
	localparam int unsigned CFG_IDX_W   = 3;
	localparam int unsigned DAY_W       = 3;
	localparam int unsigned HOUR_W      = 5;
	localparam int unsigned MIN_W       = 6;
	localparam int unsigned NUM_W       = 4;

	// Entry word layout
	localparam int unsigned EN_BIT   = 0;
	localparam int unsigned ON_H_LSB = 8;
	localparam int unsigned ON_M_LSB = 13;
	localparam int unsigned OFF_H_LSB = 19;
	localparam int unsigned OFF_M_LSB = 24;

	// Time check plus running active number, handed cell to cell.
	typedef struct packed {
		logic               valid;
		logic [DAY_W-1:0]   day;
		logic [HOUR_W-1:0]  hour;
		logic [MIN_W-1:0]   minute;
		logic [NUM_W-1:0]   active;
	} tok_t;

endpackage
`default_nettype wire

@@ sv/wst_time_if.sv @@
// Handshake channel carrying one clock time check.
`default_nettype none
interface wst_time_if;
	logic                            valid;
	logic                            ready;
	logic [wst_pkg::DAY_W-1:0]       week_day;
	logic [wst_pkg::HOUR_W-1:0]      clock_hour;
	logic [wst_pkg::MIN_W-1:0]       clock_minute;

	modport source (output valid, week_day, clock_hour, clock_minute, input ready);
	modport sink   (input valid, week_day, clock_hour, clock_minute, output ready);
endinterface
`default_nettype wire

@@ sv/wst_num_if.sv @@
// Handshake channel carrying the active entry number.
`default_nettype none
interface wst_num_if;
	logic                        valid;
	logic                        ready;
	logic [wst_pkg::NUM_W-1:0]   active_number;

	modport source (output valid, active_number, input ready);
	modport sink   (input valid, active_number, output ready);
endinterface
`default_nettype wire

@@ sv/wst_cell.sv @@
// One schedule cell: entry word, on/off latches, token register.
`default_nettype none
module wst_cell #(
	parameter int unsigned INDEX = 0
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              wr_en,
	input  wire [wst_pkg::ENTRY_W-1:0]       wr_data,
	input  wire                              advance,
	input  wire wst_pkg::tok_t               tok_in,
	output wst_pkg::tok_t                    tok_out
);

	localparam logic [wst_pkg::NUM_W-1:0] NUMBER = wst_pkg::NUM_W'(INDEX + 1);

	logic [wst_pkg::ENTRY_W-1:0] entry_q;
	logic                        on_latch_q;
	logic                        off_latch_q;
	wst_pkg::tok_t               tok_q;

	logic [wst_pkg::HOUR_W-1:0] on_h, off_h;
	logic [wst_pkg::MIN_W-1:0]  on_m, off_m;
	logic [6:0]                 day_mask;
	logic                       live, day_hit, on_hit, off_hit;
	logic                       on_nxt, off_nxt;
	logic [wst_pkg::NUM_W-1:0]  act_mid, act_nxt;
	wst_pkg::tok_t              tok_nxt;

	assign on_h     = entry_q[wst_pkg::ON_H_LSB +: wst_pkg::HOUR_W];
	assign on_m     = entry_q[wst_pkg::ON_M_LSB +: wst_pkg::MIN_W];
	assign off_h    = entry_q[wst_pkg::OFF_H_LSB +: wst_pkg::HOUR_W];
	assign off_m    = entry_q[wst_pkg::OFF_M_LSB +: wst_pkg::MIN_W];
	assign day_mask = entry_q[7:1];

	always_comb begin
		live    = entry_q[wst_pkg::EN_BIT] && !(on_h == off_h && on_m == off_m);
		// weekday zero selects no mask bit
		day_hit = (tok_in.day != '0) && day_mask[tok_in.day - 3'd1];
		on_hit  = day_hit && tok_in.hour == on_h && tok_in.minute == on_m;
		off_hit = tok_in.hour == off_h && tok_in.minute == off_m;

		on_nxt  = 1'b0;
		off_nxt = 1'b0;
		act_mid = tok_in.active;
		act_nxt = tok_in.active;
		if (live) begin
			if (on_hit) begin
				on_nxt = 1'b1;
				if (!on_latch_q) act_mid = NUMBER;
			end
			act_nxt = act_mid;
			if (act_mid == NUMBER && off_hit) begin
				off_nxt = 1'b1;
				if (!off_latch_q) act_nxt = '0;
			end
		end

		tok_nxt        = tok_in;
		tok_nxt.active = act_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q     <= '0;
			on_latch_q  <= 1'b0;
			off_latch_q <= 1'b0;
			tok_q       <= '0;
		end else begin
			if (wr_en) entry_q <= wr_data;
			if (advance) begin
				tok_q <= tok_nxt;
				if (tok_in.valid) begin
					on_latch_q  <= on_nxt;
					off_latch_q <= off_nxt;
				end
			end
		end
	end

	assign tok_out = tok_q;

endmodule
`default_nettype wire

@@ sv/weekly_time_schedule_trigger.sv @@
// Top level: weekly schedule trigger built as a chain of entry cells.
`default_nettype none
// Weekly schedule trigger. Each accepted item on "tick" is one clock check
// (weekday, hour, minute); each produces exactly one item on "result" with
// the active entry number (0 = none, else 1..ENTRIES). Schedule entries are
// written through cfg_we/cfg_index/cfg_data, one 30-bit word per entry:
// bit 0 enable, bits 7:1 Monday..Sunday mask, 12:8 on hour, 18:13 on minute,
// 23:19 off hour, 29:24 off minute. Indexes at or above ENTRIES are dropped.
// Timing: the check travels down a row of ENTRIES cells, one cell per clock
// while the chain is not stalled, then lands in the output register. The
// chain has drained by the time result valid rises, and tick is ready
// again from that point.
// The chain holds one item at a time because each check needs the active
// number left by the last cell for the previous check. A result waiting in
// the output register does not block the next item; the chain only stalls if
// a second result is ready while the first has still not been taken.
module weekly_time_schedule_trigger #(
	parameter int unsigned ENTRIES = wst_pkg::MAX_ENTRIES
) (
	input  wire                                clk,
	input  wire                                arst_n,
	wst_time_if.sink                           tick,
	wst_num_if.source                          result,
	input  wire                                cfg_we,
	input  wire [wst_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire [wst_pkg::ENTRY_W-1:0]         cfg_data
);

	wst_pkg::tok_t             chain [ENTRIES+1];
	logic [ENTRIES-1:0]        busy_vec;
	logic                      busy;
	logic                      advance;
	logic                      take;

	// active number carried between items
	logic [wst_pkg::NUM_W-1:0] active_q;
	logic                      out_valid_q;
	logic [wst_pkg::NUM_W-1:0] out_num_q;

	assign busy       = |busy_vec;
	assign tick.ready = !busy;
	assign take       = tick.valid && !busy;

	// freeze the chain only when the last cell has a result and the output is full and not being taken
	assign advance = !(chain[ENTRIES].valid && out_valid_q && !result.ready);

	assign chain[0].valid  = take;
	assign chain[0].day    = tick.week_day;
	assign chain[0].hour   = tick.clock_hour;
	assign chain[0].minute = tick.clock_minute;
	assign chain[0].active = active_q;

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		wst_cell #(.INDEX(i)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.wr_en   (cfg_we && cfg_index == wst_pkg::CFG_IDX_W'(i)),
			.wr_data (cfg_data),
			.advance (advance),
			.tok_in  (chain[i]),
			.tok_out (chain[i+1])
		);
		assign busy_vec[i] = chain[i+1].valid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= '0;
			out_valid_q <= 1'b0;
			out_num_q   <= '0;
		end else begin
			if (chain[ENTRIES].valid && advance) begin
				out_valid_q <= 1'b1;
				out_num_q   <= chain[ENTRIES].active;
				active_q    <= chain[ENTRIES].active;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result.valid         = out_valid_q;
	assign result.active_number = out_num_q;

endmodule
`default_nettype wire

@@ tb/tb_weekly_time_schedule_trigger.sv @@
// Testbench for the weekly schedule trigger: directed and random clock checks against a predictor.
`timescale 1ns / 100ps
module tb_weekly_time_schedule_trigger;

	localparam int unsigned N_ENTRIES    = wst_pkg::MAX_ENTRIES;
	localparam int unsigned WAIT_MAX     = 18;
	localparam int unsigned IDLE_LIMIT   = 2000;
	localparam int unsigned PHASES       = 12;
	localparam int unsigned PHASE_ITEMS  = 119;
	// check walks ENTRIES cells then lands in the output register
	localparam int unsigned DRAIN_CYCLES = 2 * (wst_pkg::MAX_ENTRIES + 1) + 4;

	typedef enum logic [wst_pkg::CFG_IDX_W-1:0] {
		SLOT_0, SLOT_1, SLOT_2, SLOT_3, SLOT_4, SLOT_5, SLOT_6, SLOT_7
	} slot_e;

	typedef logic [wst_pkg::ENTRY_W-1:0] entry_word_t;
	typedef logic [wst_pkg::DAY_W-1:0]   day_t;
	typedef logic [wst_pkg::HOUR_W-1:0]  hour_t;
	typedef logic [wst_pkg::MIN_W-1:0]   minute_t;
	typedef logic [wst_pkg::NUM_W-1:0]   num_t;

	// Tracks schedule state, predicts the active number per check and
	// compares each returned number with the oldest prediction.
	class schedule_tracker;
		entry_word_t      slot_word [N_ENTRIES];
		bit               on_latch  [N_ENTRIES];
		bit               off_latch [N_ENTRIES];
		num_t             active;
		num_t             expected_numbers [$];
		int unsigned      mismatch_count;

		function new();
			foreach (slot_word[i]) begin
				slot_word[i] = '0;
				on_latch[i]  = 1'b0;
				off_latch[i] = 1'b0;
			end
			active         = '0;
			mismatch_count = 0;
		endfunction

		function void write_entry(slot_e idx, entry_word_t word);
			slot_word[idx] = word;
		endfunction

		function void note_check(day_t day, hour_t hour, minute_t minute);
			entry_word_t w;
			hour_t       on_h, off_h;
			minute_t     on_m, off_m;
			num_t        number;
			bit          day_hit;
			for (int i = 0; i < N_ENTRIES; i++) begin
				w      = slot_word[i];
				on_h   = w[wst_pkg::ON_H_LSB +: wst_pkg::HOUR_W];
				on_m   = w[wst_pkg::ON_M_LSB +: wst_pkg::MIN_W];
				off_h  = w[wst_pkg::OFF_H_LSB +: wst_pkg::HOUR_W];
				off_m  = w[wst_pkg::OFF_M_LSB +: wst_pkg::MIN_W];
				number = num_t'(i + 1);
				// disabled or zero-length entries take no part
				if (!w[wst_pkg::EN_BIT] || (on_h == off_h && on_m == off_m)) begin
					on_latch[i]  = 1'b0;
					off_latch[i] = 1'b0;
					continue;
				end
				day_hit = (day != 0) && w[day];
				if (day_hit && hour == on_h && minute == on_m) begin
					if (!on_latch[i]) begin
						on_latch[i] = 1'b1;
						active      = number;
					end
				end else begin
					on_latch[i] = 1'b0;
				end
				// off time ignores the day mask, only the active entry
				if (active == number && hour == off_h && minute == off_m) begin
					if (!off_latch[i]) begin
						off_latch[i] = 1'b1;
						active       = '0;
					end
				end else begin
					off_latch[i] = 1'b0;
				end
			end
			expected_numbers.push_back(active);
		endfunction

		function void check_number(num_t got);
			num_t want;
			if (expected_numbers.size() == 0) begin
				mismatch_count++;
				$display("%0t: unexpected active_number, expected none, got %0d", $time, got);
				return;
			end
			want = expected_numbers.pop_front();
			if (got !== want) begin
				mismatch_count++;
				$display("%0t: active_number mismatch, expected %0d, got %0d",
					$time, want, got);
			end
		endfunction

		function int unsigned pending();
			return expected_numbers.size();
		endfunction
	endclass

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_we;
	logic [wst_pkg::CFG_IDX_W-1:0] cfg_index;
	entry_word_t                   cfg_data;

	wst_time_if tick_if ();
	wst_num_if  num_if ();

	weekly_time_schedule_trigger u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.tick      (tick_if),
		.result    (num_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	schedule_tracker   tracker;
	entry_word_t       plan      [N_ENTRIES];  // schedule for the next phase
	entry_word_t       cur_entry [N_ENTRIES];  // schedule now in the block
	bit                tx_burst;
	bit                rx_burst;
	day_t              last_day;
	hour_t             last_hour;
	minute_t           last_minute;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic entry_word_t pack_entry(bit en, logic [6:0] mask,
			hour_t on_h, minute_t on_m, hour_t off_h, minute_t off_m);
		return {off_m, off_h, on_m, on_h, mask, en};
	endfunction

	// Narrow mode squeezes times into a few values so entries collide,
	// which is what exercises overrides and cross-entry off times.
	function automatic entry_word_t rand_entry(bit narrow);
		bit         en;
		logic [6:0] mask;
		hour_t      on_h, off_h;
		minute_t    on_m, off_m;
		en   = $urandom_range(0, 7) != 0;
		mask = ($urandom_range(0, 3) == 0) ? 7'h7F : 7'($urandom);
		if ($urandom_range(0, 7) == 0) begin
			// raw bit patterns, out of range times included
			on_h  = hour_t'($urandom);
			on_m  = minute_t'($urandom);
			off_h = hour_t'($urandom);
			off_m = minute_t'($urandom);
		end else if (narrow) begin
			on_h  = hour_t'($urandom_range(0, 2));
			on_m  = minute_t'($urandom_range(0, 3));
			off_h = hour_t'($urandom_range(0, 2));
			off_m = minute_t'($urandom_range(0, 3));
		end else begin
			on_h  = hour_t'($urandom_range(0, 23));
			on_m  = minute_t'($urandom_range(0, 59));
			off_h = hour_t'($urandom_range(0, 23));
			off_m = minute_t'($urandom_range(0, 59));
		end
		if ($urandom_range(0, 9) == 0) begin
			off_h = on_h;
			off_m = on_m;
		end
		return pack_entry(en, mask, on_h, on_m, off_h, off_m);
	endfunction

	// Sender holds off until every outstanding result is back.
	task automatic wait_idle();
		tick_if.valid <= 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	task automatic apply_plan();
		wait_idle();
		for (int i = 0; i < N_ENTRIES; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= slot_e'(i);
			cfg_data  <= plan[i];
			@(posedge clk);
			tracker.write_entry(slot_e'(i), plan[i]);
			cur_entry[i] = plan[i];
		end
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_check(day_t day, hour_t hour, minute_t minute);
		int unsigned gap;
		gap = tx_burst ? 0 : $urandom_range(0, WAIT_MAX);
		if ($urandom_range(0, 29) == 0)
			tx_burst = !tx_burst;
		if (gap != 0) begin
			tick_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		tick_if.valid        <= 1'b1;
		tick_if.week_day     <= day;
		tick_if.clock_hour   <= hour;
		tick_if.clock_minute <= minute;
		do
			@(posedge clk);
		while (!tick_if.ready);
		tracker.note_check(day, hour, minute);
		last_day    = day;
		last_hour   = hour;
		last_minute = minute;
	endtask

	// Mostly checks that land on a programmed on or off time, some repeats
	// of the last check to hit the latches, the rest raw noise.
	task automatic random_check();
		int unsigned r, k;
		entry_word_t w;
		day_t        day;
		hour_t       hour;
		minute_t     minute;
		r = $urandom_range(0, 99);
		if (r < 10) begin
			day    = last_day;
			hour   = last_hour;
			minute = last_minute;
		end else if (r < 75) begin
			k   = $urandom_range(0, N_ENTRIES - 1);
			w   = cur_entry[k];
			day = day_t'($urandom_range(0, 7));
			if ($urandom_range(0, 4) < 3) begin
				hour   = w[wst_pkg::ON_H_LSB +: wst_pkg::HOUR_W];
				minute = w[wst_pkg::ON_M_LSB +: wst_pkg::MIN_W];
				// usually pick a day the entry is armed for
				if (w[wst_pkg::ON_H_LSB-1:wst_pkg::EN_BIT+1] != 0 &&
						$urandom_range(0, 7) != 0)
					while (day == 0 || !w[day])
						day = day_t'($urandom_range(1, 7));
			end else begin
				hour   = w[wst_pkg::OFF_H_LSB +: wst_pkg::HOUR_W];
				minute = w[wst_pkg::OFF_M_LSB +: wst_pkg::MIN_W];
			end
		end else begin
			day    = day_t'($urandom);
			hour   = hour_t'($urandom);
			minute = minute_t'($urandom);
		end
		send_check(day, hour, minute);
	endtask

	// Result side: random stalls, with burst stretches of ready held high.
	initial begin
		int unsigned stall;
		num_if.ready <= 1'b0;
		rx_burst = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = rx_burst ? 0 : $urandom_range(0, WAIT_MAX);
			if ($urandom_range(0, 29) == 0)
				rx_burst = !rx_burst;
			if (stall != 0) begin
				num_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			num_if.ready <= 1'b1;
			do
				@(posedge clk);
			while (!(num_if.valid && num_if.ready));
			tracker.check_number(num_if.active_number);
		end
	end

	// Watchdog: ends the run if neither side moves an item for too long.
	initial begin
		int unsigned idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((tick_if.valid && tick_if.ready) || (num_if.valid && num_if.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("FAILURE");
		$finish;
	end

	initial begin
		tracker = new();
		tx_burst    = 1'b0;
		last_day    = '0;
		last_hour   = '0;
		last_minute = '0;
		foreach (cur_entry[i])
			cur_entry[i] = '0;
		arst_n               <= 1'b0;
		cfg_we               <= 1'b0;
		cfg_index            <= '0;
		cfg_data             <= '0;
		tick_if.valid        <= 1'b0;
		tick_if.week_day     <= '0;
		tick_if.clock_hour   <= '0;
		tick_if.clock_minute <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed schedule:
		//   0: every day, on 08:00, off 17:30
		//   1: weekdays only, on 09:00, off 10:00
		//   2: disabled, times that would otherwise fire
		//   3: on equals off, never takes part
		//   4: Sunday only, on at the all-ones time, off at midnight
		//   6: on 17:30 (same minute as entry 0 goes off), off 17:31
		//   7: every day, on 23:59, off midnight
		plan[SLOT_0] = pack_entry(1'b1, 7'h7F,  8,  0, 17, 30);
		plan[SLOT_1] = pack_entry(1'b1, 7'h1F,  9,  0, 10,  0);
		plan[SLOT_2] = pack_entry(1'b0, 7'h7F,  8,  0,  9,  0);
		plan[SLOT_3] = pack_entry(1'b1, 7'h7F, 12,  0, 12,  0);
		plan[SLOT_4] = pack_entry(1'b1, 7'h40, 31, 63,  0,  0);
		plan[SLOT_5] = '0;
		plan[SLOT_6] = pack_entry(1'b1, 7'h7F, 17, 30, 17, 31);
		plan[SLOT_7] = pack_entry(1'b1, 7'h7F, 23, 59,  0,  0);
		apply_plan();

		send_check(1,  8,  0);  // entry 0 turns on
		send_check(1,  8,  0);  // same minute again: latched, no refire
		send_check(1,  8,  1);  // leaving the minute rearms the latch
		send_check(1,  8,  0);  // fires again
		send_check(1,  9,  0);  // later entry overrides
		send_check(1, 17, 30);  // entry 0 off time while entry 1 active: no effect, but entry 6 turns on
		send_check(1, 10,  0);  // entry 1 off time, but entry 6 is active: no effect
		send_check(1, 10,  0);
		send_check(0,  8,  0);  // weekday zero matches no mask
		send_check(6,  9,  0);  // Saturday outside entry 1 mask
		send_check(7, 31, 63);  // out of range on time, Sunday only
		send_check(3,  0,  0);  // off time fires on any weekday
		send_check(7, 23, 59);  // last entry
		send_check(5,  8,  0);
		send_check(2, 12,  0);  // equal on/off entry does nothing
		send_check(2, 17, 30);  // entry 0 off, then entry 6 on in the same walk
		send_check(2, 17, 31);  // entry 6 off
		send_check(7, 31, 63);

		for (int p = 0; p < PHASES; p++) begin
			for (int i = 0; i < N_ENTRIES; i++) begin
				case (p)
					0: begin
						// all ones: on equals off, every entry idle
						plan[i] = '1;
					end
					1: begin
						plan[i] = '0;
					end
					2: begin
						// extreme times, alternating so entries toggle each other
						plan[i] = (i % 2 == 0) ?
							pack_entry(1'b1, 7'h7F, 5'h1F, 6'h3F, 5'h00, 6'h00) :
							pack_entry(1'b1, 7'h7F, 5'h00, 6'h00, 5'h1F, 6'h3F);
					end
					default: begin
						plan[i] = rand_entry(p % 2 == 1);
					end
				endcase
			end
			apply_plan();
			repeat (PHASE_ITEMS) random_check();
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tracker.mismatch_count == 0 && tracker.pending() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
